// ----- src/wialu_pkg.sv -----
// shared definitions for the 128-bit wide integer alu
// operation codes, operand widths and the 32x32 partial-product helper
package wialu_pkg;

    localparam int OPERAND_BITS = 128;
    localparam int HALF_BITS    = OPERAND_BITS / 2;
    localparam int PART_BITS    = HALF_BITS / 2;
    localparam int CMD_BITS     = 3;
    localparam int SHAMT_BITS   = $clog2(OPERAND_BITS);

    typedef logic [OPERAND_BITS-1:0] word_t;
    typedef logic [HALF_BITS-1:0]    half_t;
    typedef logic [PART_BITS-1:0]    part_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD = 3'd0,
        CMD_NEG  = 3'd1,
        CMD_ADD  = 3'd2,
        CMD_SUB  = 3'd3,
        CMD_MUL  = 3'd4,
        CMD_SHL  = 3'd5,
        CMD_SHR  = 3'd6,
        CMD_SAR  = 3'd7
    } cmd_t;

    // one 32x32 partial product, full 64-bit result
    function automatic half_t mul_part(input part_t x, input part_t y);
        return {{PART_BITS{1'b0}}, x} * {{PART_BITS{1'b0}}, y};
    endfunction

endpackage

// ----- src/wide_integer_alu_128.sv -----
// top level of the 128-bit wide integer alu: four-stage elastic pipeline
// depends on wialu_pkg for operation codes, widths and the partial-product helper

// Takes one item per cycle unless a stall on m_ready backs it up, and returns one
// 128-bit result per item, in order, through the stage one, two and three registers
// and the output register. Stage one forms the 32x32 partial products of the
// multiply (ten of them, only those that reach the low 128 bits) and the result
// of every other operation; stage two sums the middle and cross partial products;
// stage three adds the product together and selects the result; the fourth
// register holds the result for the m_ channel. Each stage moves forward when the
// stage after it is empty or moving, so a stall on m_ready holds the output while
// the stages behind it close up; s_ready stays high as long as some stage has room.
module wide_integer_alu_128 (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [wialu_pkg::CMD_BITS-1:0]        s_cmd,
    input  logic [wialu_pkg::HALF_BITS-1:0]       s_a_lo,
    input  logic [wialu_pkg::HALF_BITS-1:0]       s_a_hi,
    input  logic [wialu_pkg::HALF_BITS-1:0]       s_b_lo,
    input  logic [wialu_pkg::HALF_BITS-1:0]       s_b_hi,
    input  logic [wialu_pkg::SHAMT_BITS-1:0]      s_shift_amount,
    input  logic signed [wialu_pkg::HALF_BITS-1:0] s_long_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [wialu_pkg::HALF_BITS-1:0]       m_res_lo,
    output logic [wialu_pkg::HALF_BITS-1:0]       m_res_hi
);

    localparam int PB = wialu_pkg::PART_BITS;
    localparam int HB = wialu_pkg::HALF_BITS;

    // stage enables, ready ripples back from the output register
    logic en1, en2, en3, en_out;
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;

    assign en_out  = !m_valid_reg || m_ready;
    assign en3     = !v3_reg || en_out;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = m_valid_reg;

    // ---------------- stage one ----------------
    wialu_pkg::word_t a_word, alt_next;
    wialu_pkg::cmd_t  cmd;
    wialu_pkg::part_t a0, a1, a2, a3, b0, b1, b2, b3;
    wialu_pkg::half_t p00_next, p01_next, p10_next, p11_next, q02_next, r20_next;
    wialu_pkg::half_t q12_full, q03_full, r30_full, r21_full;

    assign a_word = {s_a_hi, s_a_lo};
    assign cmd    = wialu_pkg::cmd_t'(s_cmd);
    assign a0 = s_a_lo[PB-1:0];
    assign a1 = s_a_lo[HB-1:PB];
    assign a2 = s_a_hi[PB-1:0];
    assign a3 = s_a_hi[HB-1:PB];
    assign b0 = s_b_lo[PB-1:0];
    assign b1 = s_b_lo[HB-1:PB];
    assign b2 = s_b_hi[PB-1:0];
    assign b3 = s_b_hi[HB-1:PB];

    // a_lo * b_lo in full
    assign p00_next = wialu_pkg::mul_part(a0, b0);
    assign p01_next = wialu_pkg::mul_part(a0, b1);
    assign p10_next = wialu_pkg::mul_part(a1, b0);
    assign p11_next = wialu_pkg::mul_part(a1, b1);
    // low 64 bits of a_lo * b_hi and a_hi * b_lo
    assign q02_next = wialu_pkg::mul_part(a0, b2);
    assign q12_full = wialu_pkg::mul_part(a1, b2);
    assign q03_full = wialu_pkg::mul_part(a0, b3);
    assign r20_next = wialu_pkg::mul_part(a2, b0);
    assign r30_full = wialu_pkg::mul_part(a3, b0);
    assign r21_full = wialu_pkg::mul_part(a2, b1);

    always_comb begin
        unique case (cmd)
            wialu_pkg::CMD_LOAD: alt_next = {{HB{s_long_value[HB-1]}}, s_long_value};
            wialu_pkg::CMD_NEG:  alt_next = ~a_word + wialu_pkg::word_t'(1);
            wialu_pkg::CMD_ADD:  alt_next = a_word + {s_b_hi, s_b_lo};
            wialu_pkg::CMD_SUB:  alt_next = a_word - {s_b_hi, s_b_lo};
            wialu_pkg::CMD_MUL:  alt_next = '0;
            wialu_pkg::CMD_SHL:  alt_next = a_word << s_shift_amount;
            wialu_pkg::CMD_SHR:  alt_next = a_word >> s_shift_amount;
            wialu_pkg::CMD_SAR:  alt_next = wialu_pkg::word_t'($signed(a_word) >>> s_shift_amount);
            default:             alt_next = '0;
        endcase
    end

    wialu_pkg::half_t p00_reg, p01_reg, p10_reg, p11_reg, q02_reg, r20_reg;
    wialu_pkg::part_t q12_reg, q03_reg, r30_reg, r21_reg;
    wialu_pkg::word_t alt1_reg;
    logic             mul1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            p00_reg  <= p00_next;
            p01_reg  <= p01_next;
            p10_reg  <= p10_next;
            p11_reg  <= p11_next;
            q02_reg  <= q02_next;
            r20_reg  <= r20_next;
            q12_reg  <= q12_full[PB-1:0];
            q03_reg  <= q03_full[PB-1:0];
            r30_reg  <= r30_full[PB-1:0];
            r21_reg  <= r21_full[PB-1:0];
            alt1_reg <= alt_next;
            mul1_reg <= (cmd == wialu_pkg::CMD_MUL);
        end
    end

    // ---------------- stage two ----------------
    logic [HB:0]      mid_next;
    wialu_pkg::part_t cross_top;
    wialu_pkg::half_t cross_next;

    assign mid_next   = {1'b0, p01_reg} + {1'b0, p10_reg};
    assign cross_top  = q12_reg + q03_reg + r30_reg + r21_reg;
    assign cross_next = q02_reg + r20_reg + {cross_top, {PB{1'b0}}};

    logic [HB:0]      mid_reg;
    wialu_pkg::half_t cross_reg, p00_2_reg, p11_2_reg;
    wialu_pkg::word_t alt2_reg;
    logic             mul2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            mid_reg   <= mid_next;
            cross_reg <= cross_next;
            p00_2_reg <= p00_reg;
            p11_2_reg <= p11_reg;
            alt2_reg  <= alt1_reg;
            mul2_reg  <= mul1_reg;
        end
    end

    // ---------------- stage three ----------------
    wialu_pkg::word_t prod, res_next;

    assign prod = {p11_2_reg, p00_2_reg}
                + {{(PB-1){1'b0}}, mid_reg, {PB{1'b0}}}
                + {cross_reg, {HB{1'b0}}};
    assign res_next = mul2_reg ? prod : alt2_reg;

    wialu_pkg::word_t res3_reg, out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            res3_reg <= res_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_out) begin
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            out_reg <= res3_reg;
        end
    end

    assign m_res_lo = out_reg[HB-1:0];
    assign m_res_hi = out_reg[wialu_pkg::OPERAND_BITS-1:HB];

endmodule

// ----- src/wialu_checker.sv -----
// port-level checks for wide_integer_alu_128, attached by the bind below
// depends on wialu_pkg for port widths
module wialu_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [wialu_pkg::HALF_BITS-1:0]  m_res_lo,
    input logic [wialu_pkg::HALF_BITS-1:0]  m_res_hi
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res_lo) && $stable(m_res_hi))
        else $error("result changed or dropped while stalled");

    // reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a ready result side never backs up the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is ready");

    // with no stall an accepted item reaches m_valid through every stage register and the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && m_ready ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("item did not reach the output in four cycles");

endmodule

bind wide_integer_alu_128 wialu_checker u_wialu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_res_lo (m_res_lo),
    .m_res_hi (m_res_hi)
);

// ----- sim/tb.sv -----
// testbench for wide_integer_alu_128: a directed table, then random items, checked in order
// against a 128-bit arithmetic predictor; depends on wialu_pkg and the alu top level

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 825;
    localparam int TOTAL_ITEMS = N_DIRECTED + N_RANDOM;
    localparam int CALM_ITEMS  = 80;
    localparam int LONG_HOLD   = 80;
    localparam int TAIL_CYCLES = 8;
    localparam int CYCLE_LIMIT = 100000;

    typedef logic [wialu_pkg::SHAMT_BITS-1:0] count_t;

    localparam wialu_pkg::word_t ONES      = '1;
    localparam wialu_pkg::word_t MSB       =
        wialu_pkg::word_t'(1) << (wialu_pkg::OPERAND_BITS - 1);
    localparam wialu_pkg::half_t HALF_ONES = '1;
    localparam wialu_pkg::half_t HALF_MSB  =
        wialu_pkg::half_t'(1) << (wialu_pkg::HALF_BITS - 1);

    typedef struct packed {
        wialu_pkg::cmd_t                  op;
        wialu_pkg::word_t                 a;
        wialu_pkg::word_t                 b;
        logic [wialu_pkg::SHAMT_BITS-1:0] n;
        wialu_pkg::half_t                 lv;
        logic                             known;
        wialu_pkg::word_t                 res;
    } alu_row_t;

    logic                                   aclk = 1'b0;
    logic                                   aresetn = 1'b0;
    logic                                   s_valid = 1'b0;
    logic                                   s_ready;
    logic [wialu_pkg::CMD_BITS-1:0]         s_cmd = '0;
    wialu_pkg::half_t                       s_a_lo = '0;
    wialu_pkg::half_t                       s_a_hi = '0;
    wialu_pkg::half_t                       s_b_lo = '0;
    wialu_pkg::half_t                       s_b_hi = '0;
    logic [wialu_pkg::SHAMT_BITS-1:0]       s_shift_amount = '0;
    logic signed [wialu_pkg::HALF_BITS-1:0] s_long_value = '0;
    logic                                   m_valid;
    logic                                   m_ready = 1'b0;
    wialu_pkg::half_t                       m_res_lo;
    wialu_pkg::half_t                       m_res_hi;

    wialu_pkg::word_t pending_results[$];
    int unsigned      items_sent = 0;
    int unsigned      n_errors = 0;
    int unsigned      cycle_count = 0;
    bit               long_hold_done = 1'b0;

    // rows with known = 0 take their result from the predictor
    alu_row_t directed [N_DIRECTED] = '{
        '{wialu_pkg::CMD_LOAD, 0, 0, 7'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1,
          {64'h0, 64'h7FFF_FFFF_FFFF_FFFF}},
        '{wialu_pkg::CMD_LOAD, ONES, ONES, 7'd127, HALF_MSB, 1'b1, {HALF_ONES, HALF_MSB}},
        '{wialu_pkg::CMD_LOAD, 0, 0, 7'd0, HALF_ONES, 1'b1, ONES},
        '{wialu_pkg::CMD_LOAD, ONES, ONES, 7'd127, 64'h0, 1'b1, 0},
        '{wialu_pkg::CMD_NEG, 0, ONES, 7'd127, HALF_ONES, 1'b1, 0},
        '{wialu_pkg::CMD_NEG, 1, 0, 7'd0, 64'h0, 1'b1, ONES},
        '{wialu_pkg::CMD_NEG, MSB, 0, 7'd0, 64'h0, 1'b1, MSB},
        '{wialu_pkg::CMD_ADD, ONES, 1, 7'd0, 64'h0, 1'b1, 0},
        '{wialu_pkg::CMD_ADD, {64'h0, HALF_ONES}, 1, 7'd0, 64'h0, 1'b1, {64'h1, 64'h0}},
        '{wialu_pkg::CMD_ADD, MSB - 1, MSB - 1, 7'd0, 64'h0, 1'b0, 0},
        '{wialu_pkg::CMD_SUB, 0, 1, 7'd0, 64'h0, 1'b1, ONES},
        '{wialu_pkg::CMD_SUB, {64'h1, 64'h0}, 1, 7'd0, 64'h0, 1'b1, {64'h0, HALF_ONES}},
        '{wialu_pkg::CMD_MUL, ONES, ONES, 7'd0, 64'h0, 1'b1, 1},
        '{wialu_pkg::CMD_MUL, {64'h1, 64'h0}, {64'h1, 64'h0}, 7'd0, 64'h0, 1'b1, 0},
        '{wialu_pkg::CMD_MUL, {64'h0, HALF_ONES}, {64'h0, HALF_ONES}, 7'd0, 64'h0, 1'b0, 0},
        '{wialu_pkg::CMD_SHL, 1, ONES, 7'd127, 64'h0, 1'b1, MSB},
        '{wialu_pkg::CMD_SHL, ONES, 0, 7'd0, 64'h0, 1'b1, ONES},
        '{wialu_pkg::CMD_SHL, ONES, 0, 7'd64, 64'h0, 1'b1, {HALF_ONES, 64'h0}},
        '{wialu_pkg::CMD_SHR, MSB, 0, 7'd127, 64'h0, 1'b1, 1},
        '{wialu_pkg::CMD_SHR, ONES, 0, 7'd64, 64'h0, 1'b1, {64'h0, HALF_ONES}},
        '{wialu_pkg::CMD_SAR, MSB, 0, 7'd127, 64'h0, 1'b1, ONES},
        '{wialu_pkg::CMD_SAR, MSB, 0, 7'd5, 64'h0, 1'b0, 0},
        '{wialu_pkg::CMD_SAR, MSB, 0, 7'd70, 64'h0, 1'b0, 0},
        '{wialu_pkg::CMD_SAR, MSB - 1, 0, 7'd63, 64'h0, 1'b0, 0},
        '{wialu_pkg::CMD_SAR, ONES, 0, 7'd0, 64'h0, 1'b1, ONES}
    };

    wide_integer_alu_128 uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_a_lo         (s_a_lo),
        .s_a_hi         (s_a_hi),
        .s_b_lo         (s_b_lo),
        .s_b_hi         (s_b_hi),
        .s_shift_amount (s_shift_amount),
        .s_long_value   (s_long_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_res_lo       (m_res_lo),
        .m_res_hi       (m_res_hi)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // everything wraps modulo 2^128 since all terms are 128 bits wide
    function automatic wialu_pkg::word_t alu_result(input wialu_pkg::cmd_t op,
                                                    input wialu_pkg::word_t a,
                                                    input wialu_pkg::word_t b,
                                                    input logic [wialu_pkg::SHAMT_BITS-1:0] n,
                                                    input wialu_pkg::half_t lv);
        wialu_pkg::word_t r;
        case (op)
            wialu_pkg::CMD_LOAD: r = {{wialu_pkg::HALF_BITS{lv[wialu_pkg::HALF_BITS-1]}}, lv};
            wialu_pkg::CMD_NEG:  r = -a;
            wialu_pkg::CMD_ADD:  r = a + b;
            wialu_pkg::CMD_SUB:  r = a - b;
            wialu_pkg::CMD_MUL:  r = a * b;
            wialu_pkg::CMD_SHL:  r = a << n;
            wialu_pkg::CMD_SHR:  r = a >> n;
            default:             r = wialu_pkg::word_t'($signed(a) >>> n);
        endcase
        return r;
    endfunction

    function automatic wialu_pkg::word_t pick_operand();
        wialu_pkg::word_t w;
        w = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0: w = 0;
            1: w = ONES;
            2: w = wialu_pkg::word_t'(1) << $urandom_range(0, wialu_pkg::OPERAND_BITS - 1);
            3: w = wialu_pkg::word_t'($urandom_range(0, 255));
            4: w = -wialu_pkg::word_t'($urandom_range(1, 255));
            5: w = $urandom_range(0, 1) ? MSB : MSB - 1;
            6: w = {64'h0, w[wialu_pkg::HALF_BITS-1:0]};
            7: w = {w[wialu_pkg::OPERAND_BITS-1:wialu_pkg::HALF_BITS], 64'h0};
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [wialu_pkg::SHAMT_BITS-1:0] pick_count();
        logic [wialu_pkg::SHAMT_BITS-1:0] n;
        n = count_t'($urandom_range(0, wialu_pkg::OPERAND_BITS - 1));
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 8))
                0: n = 7'd0;
                1: n = 7'd1;
                2: n = 7'd7;
                3: n = 7'd8;
                4: n = 7'd9;
                5: n = 7'd63;
                6: n = 7'd64;
                7: n = 7'd65;
                default: n = 7'd127;
            endcase
        end
        return n;
    endfunction

    function automatic wialu_pkg::half_t pick_long();
        wialu_pkg::half_t v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = ~HALF_MSB;
            1: v = HALF_MSB;
            2: v = wialu_pkg::half_t'($signed($urandom_range(0, 255)) - 128);
            default: ;
        endcase
        return v;
    endfunction

    task automatic offer(input wialu_pkg::cmd_t op, input wialu_pkg::word_t a,
                         input wialu_pkg::word_t b,
                         input logic [wialu_pkg::SHAMT_BITS-1:0] n,
                         input wialu_pkg::half_t lv, input wialu_pkg::word_t result);
        if (items_sent < TOTAL_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= op;
        s_a_lo         <= a[wialu_pkg::HALF_BITS-1:0];
        s_a_hi         <= a[wialu_pkg::OPERAND_BITS-1:wialu_pkg::HALF_BITS];
        s_b_lo         <= b[wialu_pkg::HALF_BITS-1:0];
        s_b_hi         <= b[wialu_pkg::OPERAND_BITS-1:wialu_pkg::HALF_BITS];
        s_shift_amount <= n;
        s_long_value   <= lv;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(result);
        items_sent++;
    endtask

    // result side: short random stalls, one long hold so the pipeline backs up
    initial begin
        wait (aresetn);
        forever begin
            if (!long_hold_done && items_sent >= 200) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (items_sent < TOTAL_ITEMS - CALM_ITEMS && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        wialu_pkg::word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no item pending: res_lo %h res_hi %h", m_res_lo, m_res_hi);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_res_lo !== want[wialu_pkg::HALF_BITS-1:0]) begin
                    $error("res_lo: expected %h, got %h",
                           want[wialu_pkg::HALF_BITS-1:0], m_res_lo);
                    n_errors++;
                end
                if (m_res_hi !== want[wialu_pkg::OPERAND_BITS-1:wialu_pkg::HALF_BITS]) begin
                    $error("res_hi: expected %h, got %h",
                           want[wialu_pkg::OPERAND_BITS-1:wialu_pkg::HALF_BITS], m_res_hi);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        alu_row_t                         row;
        wialu_pkg::cmd_t                  op;
        wialu_pkg::word_t                 a;
        wialu_pkg::word_t                 b;
        logic [wialu_pkg::SHAMT_BITS-1:0] n;
        wialu_pkg::half_t                 lv;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed[i];
            offer(row.op, row.a, row.b, row.n, row.lv,
                  row.known ? row.res : alu_result(row.op, row.a, row.b, row.n, row.lv));
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            op = wialu_pkg::cmd_t'($urandom_range(0, 7));
            a  = pick_operand();
            b  = pick_operand();
            n  = pick_count();
            lv = pick_long();
            offer(op, a, b, n, lv, alu_result(op, a, b, n, lv));
        end
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
